// ===== sv/fgeb_pkg.sv =====
// Shared types, constants and codes for the filtered glyph edit buffer.
// No dependencies; the top, the filter and the sequencer import this package.
package fgeb_pkg;

    // Buffer geometry.
    localparam int C_DEPTH = 64;
    localparam int C_AW    = $clog2(C_DEPTH);
    localparam int C_CW    = $clog2(C_DEPTH + 1);
    localparam int C_XW    = (C_CW > 7) ? C_CW : 7;
    localparam int C_GW    = 35;

    // Bounds of the visible ASCII range.
    localparam logic [7:0] C_VIS_LO = 8'h20;
    localparam logic [7:0] C_VIS_HI = 8'h7e;

    typedef logic [C_AW-1:0] t_addr;
    typedef logic [C_CW-1:0] t_cnt;
    typedef logic [C_XW-1:0] t_wide;

    // Operation codes of an input item.
    typedef enum logic [3:0] {
        OP_INSERT    = 4'd0,
        OP_BACKSPACE = 4'd1,
        OP_ERASE     = 4'd2,
        OP_REPLACE   = 4'd3,
        OP_SETCURSOR = 4'd4,
        OP_LEFT      = 4'd5,
        OP_RIGHT     = 4'd6,
        OP_HOME      = 4'd7,
        OP_END       = 4'd8,
        OP_CLEAR     = 4'd9,
        OP_READ      = 4'd10
    } t_op;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_CHAR_LIMIT    = 2'd0,
        CFG_FILTER_MODE   = 2'd1,
        CFG_EMPTY_ALLOWED = 2'd2
    } t_cfg_idx;

    // Glyph filter modes.
    typedef enum logic [1:0] {
        FM_FREE    = 2'd0,
        FM_DECIMAL = 2'd1,
        FM_VISIBLE = 2'd2,
        FM_HEX     = 2'd3
    } t_filter_mode;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MOVE,
        S_WRITE,
        S_RDWAIT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [6:0] char_limit;
        logic [1:0] filter_mode;
        logic       empty_allowed;
    } t_cfg;

    typedef struct packed {
        logic       en;
        logic [6:0] value;
    } t_lim_wr;

    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  len;
    } t_glyph;

endpackage

// ===== sv/filtered_glyph_edit_buffer.sv =====
// Every item passes S_IDLE, S_EXEC and S_FIN. Cursor moves, clear, set cursor, replace,
// refused edits and a delete of the last entry go from S_EXEC straight to S_FIN; a read
// inside the buffer adds S_RDWAIT, an insert adds S_WRITE, after S_MOVE unless at the
// end, and other deletes add S_MOVE, where the entries shift one per cycle through the
// glyph RAM. A stalled result holds the block in S_FIN for its stall.
// Synchronous active-low reset empties the buffer and sets limit 0, free, empty allowed.
module filtered_glyph_edit_buffer
    import fgeb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    // Input item channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_operation,
    input  logic [31:0] i_glyph_bytes,
    input  logic [2:0]  i_glyph_length,
    input  logic [6:0]  i_position,
    // Result item channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_accepted,
    output logic [6:0]  o_entry_count,
    output logic [6:0]  o_cursor_position,
    output logic [31:0] o_read_bytes,
    output logic [2:0]  o_read_length,
    output logic        o_acceptable
);

    t_cfg            r_cfg, n_cfg;
    t_lim_wr         w_lim_wr;
    t_glyph          w_glyph;
    logic            w_pass;
    logic [31:0]     w_clean_bytes;
    logic            w_ram_we;
    t_addr           w_ram_waddr;
    logic [C_GW-1:0] w_ram_wdata;
    t_addr           w_ram_raddr;
    logic [C_GW-1:0] w_ram_rdata;

    // Configuration register file.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CHAR_LIMIT:    n_cfg.char_limit    = i_cfg_data;
                CFG_FILTER_MODE:   n_cfg.filter_mode   = i_cfg_data[1:0];
                CFG_EMPTY_ALLOWED: n_cfg.empty_allowed = i_cfg_data[0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.char_limit    <= 7'd0;
            r_cfg.filter_mode   <= FM_FREE;
            r_cfg.empty_allowed <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // A limit write also clamps count and cursor in the sequencer.
    assign w_lim_wr.en    = i_cfg_we && (i_cfg_index == CFG_CHAR_LIMIT);
    assign w_lim_wr.value = i_cfg_data;

    fgeb_filter u_filter (
        .i_filter_mode (r_cfg.filter_mode),
        .i_glyph       (w_glyph),
        .o_pass        (w_pass),
        .o_clean_bytes (w_clean_bytes)
    );

    fgeb_ram #(
        .WIDTH (C_GW),
        .DEPTH (C_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    fgeb_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_glyph_bytes     (i_glyph_bytes),
        .i_glyph_length    (i_glyph_length),
        .i_position        (i_position),
        .i_cfg             (r_cfg),
        .i_lim_wr          (w_lim_wr),
        .o_glyph           (w_glyph),
        .i_pass            (w_pass),
        .i_clean_bytes     (w_clean_bytes),
        .o_ram_we          (w_ram_we),
        .o_ram_waddr       (w_ram_waddr),
        .o_ram_wdata       (w_ram_wdata),
        .o_ram_raddr       (w_ram_raddr),
        .i_ram_rdata       (w_ram_rdata),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_accepted        (o_accepted),
        .o_entry_count     (o_entry_count),
        .o_cursor_position (o_cursor_position),
        .o_read_bytes      (o_read_bytes),
        .o_read_length     (o_read_length),
        .o_acceptable      (o_acceptable)
    );

endmodule

// ===== sv/fgeb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fgeb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/fgeb_filter.sv =====
// Glyph filter: checks a glyph against the filter mode and clears stray bytes.
// Depends on fgeb_pkg.
module fgeb_filter
    import fgeb_pkg::*;
(
    input  logic [1:0]  i_filter_mode,
    input  t_glyph      i_glyph,
    output logic        o_pass,
    output logic [31:0] o_clean_bytes
);

    logic [7:0] w_b;
    logic       w_digit;
    logic       w_hex;
    logic       w_visible;

    assign w_b = i_glyph.bytes[7:0];

    // Character class tests on the first byte.
    always_comb begin
        w_digit   = w_b inside {[8'h30:8'h39]};
        w_hex     = w_b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
        w_visible = w_b inside {[C_VIS_LO:C_VIS_HI]};
    end

    // Pass decision: a glyph must hold one to four bytes; the narrow modes want one byte.
    always_comb begin
        o_pass = 1'b0;
        if (i_glyph.len inside {[3'd1:3'd4]}) begin
            case (t_filter_mode'(i_filter_mode))
                FM_FREE:    o_pass = 1'b1;
                FM_DECIMAL: o_pass = (i_glyph.len == 3'd1) && w_digit;
                FM_VISIBLE: o_pass = (i_glyph.len == 3'd1) && w_visible;
                FM_HEX:     o_pass = (i_glyph.len == 3'd1) && w_hex;
                default:    o_pass = 1'b0;
            endcase
        end
    end

    // Bytes above the glyph length are cleared before storing.
    always_comb begin
        case (i_glyph.len)
            3'd0:    o_clean_bytes = 32'h0;
            3'd1:    o_clean_bytes = {24'h0, i_glyph.bytes[7:0]};
            3'd2:    o_clean_bytes = {16'h0, i_glyph.bytes[15:0]};
            3'd3:    o_clean_bytes = {8'h0, i_glyph.bytes[23:0]};
            default: o_clean_bytes = i_glyph.bytes;
        endcase
    end

endmodule

// ===== sv/fgeb_ctrl.sv =====
// Sequencer of the edit buffer: holds count and cursor, drives the glyph RAM,
// shifts entries for insert and delete, and registers the result item.
// Depends on fgeb_pkg.
module fgeb_ctrl
    import fgeb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input item channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [3:0]        i_operation,
    input  logic [31:0]       i_glyph_bytes,
    input  logic [2:0]        i_glyph_length,
    input  logic [6:0]        i_position,
    // Configuration
    input  t_cfg              i_cfg,
    input  t_lim_wr           i_lim_wr,
    // Filter
    output t_glyph            o_glyph,
    input  logic              i_pass,
    input  logic [31:0]       i_clean_bytes,
    // Glyph RAM
    output logic              o_ram_we,
    output t_addr             o_ram_waddr,
    output logic [C_GW-1:0]   o_ram_wdata,
    output t_addr             o_ram_raddr,
    input  logic [C_GW-1:0]   i_ram_rdata,
    // Result item channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_accepted,
    output logic [6:0]        o_entry_count,
    output logic [6:0]        o_cursor_position,
    output logic [31:0]       o_read_bytes,
    output logic [2:0]        o_read_length,
    output logic              o_acceptable
);

    t_state      r_state, n_state;
    t_op         r_op, n_op;
    t_glyph      r_glyph, n_glyph;
    logic [6:0]  r_pos, n_pos;
    t_cnt        r_count, n_count;
    t_cnt        r_cursor, n_cursor;
    logic        r_ok, n_ok;
    logic [31:0] r_rbytes, n_rbytes;
    logic [2:0]  r_rlen, n_rlen;
    t_addr       r_at, n_at;
    t_addr       r_rd_addr, n_rd_addr;
    t_cnt        r_left, n_left;
    logic        r_wr_pend, n_wr_pend;
    t_addr       r_wr_addr, n_wr_addr;
    logic        r_ins, n_ins;
    logic        r_out_valid, n_out_valid;
    logic        r_o_ok, n_o_ok;
    logic [6:0]  r_o_count, n_o_count;
    logic [6:0]  r_o_cursor, n_o_cursor;
    logic [31:0] r_o_rbytes, n_o_rbytes;
    logic [2:0]  r_o_rlen, n_o_rlen;
    logic        r_o_acc, n_o_acc;

    logic  w_accept;
    logic  w_out_free;
    logic  w_pos_in;
    logic  w_ins_ok;
    t_cnt  w_ins_at;
    logic  w_del_ok;
    t_cnt  w_del_at;
    t_cnt  w_del_moves;
    t_cnt  w_lim_count;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_glyph    = r_glyph;

    // Decode of the latched operation against the current count and cursor.
    always_comb begin
        w_pos_in = C_XW'(r_pos) < C_XW'(r_count);
        w_ins_ok = i_pass && (C_XW'(r_count) < C_XW'(C_DEPTH)) &&
                   ((i_cfg.char_limit == 7'd0) ||
                    (C_XW'(r_count) < C_XW'(i_cfg.char_limit)));
        w_ins_at = (r_cursor < r_count) ? r_cursor : r_count;
        if (r_op == OP_BACKSPACE) begin
            w_del_ok = (r_cursor != '0) && (r_count != '0) && (r_cursor <= r_count);
            w_del_at = r_cursor - t_cnt'(1);
        end else begin
            w_del_ok = r_cursor < r_count;
            w_del_at = r_cursor;
        end
        w_del_moves = r_count - t_cnt'(1) - w_del_at;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_op)
                    OP_INSERT: begin
                        if (!w_ins_ok) begin
                            n_state = S_FIN;
                        end else if (w_ins_at == r_count) begin
                            n_state = S_WRITE;
                        end else begin
                            n_state = S_MOVE;
                        end
                    end
                    OP_BACKSPACE, OP_ERASE: begin
                        if (w_del_ok && (w_del_moves != '0)) begin
                            n_state = S_MOVE;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                    OP_READ: n_state = w_pos_in ? S_RDWAIT : S_FIN;
                    default: n_state = S_FIN;
                endcase
            end
            S_MOVE: begin
                if ((r_left == '0) && !r_wr_pend) begin
                    n_state = r_ins ? S_WRITE : S_FIN;
                end
            end
            S_WRITE:  n_state = S_FIN;
            S_RDWAIT: n_state = S_FIN;
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, RAM control and result register loading.
    always_comb begin
        n_op        = r_op;
        n_glyph     = r_glyph;
        n_pos       = r_pos;
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_ok        = r_ok;
        n_rbytes    = r_rbytes;
        n_rlen      = r_rlen;
        n_at        = r_at;
        n_rd_addr   = r_rd_addr;
        n_left      = r_left;
        n_wr_pend   = r_wr_pend;
        n_wr_addr   = r_wr_addr;
        n_ins       = r_ins;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_ok      = r_o_ok;
        n_o_count   = r_o_count;
        n_o_cursor  = r_o_cursor;
        n_o_rbytes  = r_o_rbytes;
        n_o_rlen    = r_o_rlen;
        n_o_acc     = r_o_acc;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_at;
        o_ram_wdata = {r_glyph.len, i_clean_bytes};
        o_ram_raddr = r_rd_addr;

        case (r_state)
            // Latch the item.
            S_IDLE: begin
                if (w_accept) begin
                    n_op          = t_op'(i_operation);
                    n_glyph.bytes = i_glyph_bytes;
                    n_glyph.len   = i_glyph_length;
                    n_pos         = i_position;
                    n_ok          = 1'b0;
                    n_rbytes      = 32'h0;
                    n_rlen        = 3'd0;
                end
            end
            // Apply the operation to count and cursor and set up any shift.
            S_EXEC: begin
                case (r_op)
                    OP_INSERT: begin
                        if (w_ins_ok) begin
                            n_ok      = 1'b1;
                            n_at      = t_addr'(w_ins_at);
                            n_rd_addr = t_addr'(r_count - t_cnt'(1));
                            n_left    = r_count - w_ins_at;
                            n_ins     = 1'b1;
                            n_count   = r_count + t_cnt'(1);
                            n_cursor  = w_ins_at + t_cnt'(1);
                        end
                    end
                    OP_BACKSPACE, OP_ERASE: begin
                        if (w_del_ok) begin
                            n_ok      = 1'b1;
                            n_rd_addr = t_addr'(w_del_at + t_cnt'(1));
                            n_left    = w_del_moves;
                            n_ins     = 1'b0;
                            n_count   = r_count - t_cnt'(1);
                            if (r_op == OP_BACKSPACE) begin
                                n_cursor = r_cursor - t_cnt'(1);
                            end
                        end
                    end
                    OP_REPLACE: begin
                        if (w_pos_in && i_pass) begin
                            n_ok        = 1'b1;
                            o_ram_we    = 1'b1;
                            o_ram_waddr = t_addr'(r_pos);
                        end
                    end
                    OP_SETCURSOR: begin
                        n_ok     = 1'b1;
                        n_cursor = w_pos_in ? t_cnt'(r_pos) : r_count;
                    end
                    OP_LEFT: begin
                        n_ok = 1'b1;
                        if (r_cursor != '0) begin
                            n_cursor = r_cursor - t_cnt'(1);
                        end
                    end
                    OP_RIGHT: begin
                        n_ok = 1'b1;
                        if (r_cursor < r_count) begin
                            n_cursor = r_cursor + t_cnt'(1);
                        end
                    end
                    OP_HOME: begin
                        n_ok     = 1'b1;
                        n_cursor = '0;
                    end
                    OP_END: begin
                        n_ok     = 1'b1;
                        n_cursor = r_count;
                    end
                    OP_CLEAR: begin
                        n_ok     = 1'b1;
                        n_count  = '0;
                        n_cursor = '0;
                    end
                    OP_READ: begin
                        if (w_pos_in) begin
                            n_ok        = 1'b1;
                            o_ram_raddr = t_addr'(r_pos);
                        end
                    end
                    default: begin
                        n_ok = 1'b0;
                    end
                endcase
            end
            // One entry read per cycle; the entry from the previous read is written one place on.
            S_MOVE: begin
                o_ram_we    = r_wr_pend;
                o_ram_waddr = r_wr_addr;
                o_ram_wdata = i_ram_rdata;
                if (r_left != '0) begin
                    n_left    = r_left - t_cnt'(1);
                    n_wr_pend = 1'b1;
                    if (r_ins) begin
                        n_rd_addr = r_rd_addr - t_addr'(1);
                        n_wr_addr = r_rd_addr + t_addr'(1);
                    end else begin
                        n_rd_addr = r_rd_addr + t_addr'(1);
                        n_wr_addr = r_rd_addr - t_addr'(1);
                    end
                end else begin
                    n_wr_pend = 1'b0;
                end
            end
            // Store the new glyph at the insert point.
            S_WRITE: begin
                o_ram_we = 1'b1;
            end
            S_RDWAIT: begin
                n_rbytes = i_ram_rdata[31:0];
                n_rlen   = i_ram_rdata[C_GW-1:32];
            end
            // Hand the result to the output register.
            S_FIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_o_ok      = r_ok;
                    n_o_count   = 7'(r_count);
                    n_o_cursor  = 7'(r_cursor);
                    n_o_rbytes  = r_rbytes;
                    n_o_rlen    = r_rlen;
                    n_o_acc     = (r_count != '0) || i_cfg.empty_allowed;
                end
            end
            default: begin
                n_ok = r_ok;
            end
        endcase

        // A lower nonzero character limit truncates the buffer and clamps the cursor.
        if (i_lim_wr.en) begin
            w_lim_count = r_count;
            if ((i_lim_wr.value != 7'd0) &&
                (C_XW'(r_count) > C_XW'(i_lim_wr.value))) begin
                w_lim_count = t_cnt'(i_lim_wr.value);
            end
            n_count = w_lim_count;
            if (r_cursor > w_lim_count) begin
                n_cursor = w_lim_count;
            end
        end else begin
            w_lim_count = r_count;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cursor    <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_wr_pend   <= n_wr_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_glyph    <= n_glyph;
        r_pos      <= n_pos;
        r_ok       <= n_ok;
        r_rbytes   <= n_rbytes;
        r_rlen     <= n_rlen;
        r_at       <= n_at;
        r_rd_addr  <= n_rd_addr;
        r_left     <= n_left;
        r_wr_addr  <= n_wr_addr;
        r_ins      <= n_ins;
        r_o_ok     <= n_o_ok;
        r_o_count  <= n_o_count;
        r_o_cursor <= n_o_cursor;
        r_o_rbytes <= n_o_rbytes;
        r_o_rlen   <= n_o_rlen;
        r_o_acc    <= n_o_acc;
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_accepted        = r_o_ok;
    assign o_entry_count     = r_o_count;
    assign o_cursor_position = r_o_cursor;
    assign o_read_bytes      = r_o_rbytes;
    assign o_read_length     = r_o_rlen;
    assign o_acceptable      = r_o_acc;

endmodule
